// File: hw/rtl/cfinor_pkg.sv
// Package for the CFI-style NOR flash command model: modes, command bytes,
// query offsets, controller states and the decoder result struct.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package cfinor_pkg;

  localparam int unsigned ADDR_BITS_DEF  = 16;
  localparam int unsigned BLOCK_BITS_DEF = 12;

  localparam int unsigned BUS_ADDR_W = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned MODE_W     = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARRAY  = 3'd0,
    MODE_QUERY  = 3'd1,
    MODE_STATUS = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_PROG   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  // Command bytes.
  localparam logic [7:0] CMD_READ_ARRAY  = 8'hFF;
  localparam logic [7:0] CMD_QUERY       = 8'h98;
  localparam logic [7:0] CMD_READ_STATUS = 8'h70;
  localparam logic [7:0] CMD_ERASE_SETUP = 8'h20;
  localparam logic [7:0] CMD_PROG_SETUP  = 8'h40;
  localparam logic [7:0] CMD_CLEAR_STAT  = 8'h50;
  localparam logic [7:0] CMD_CONFIRM     = 8'hD0;

  // Status byte bits.
  localparam logic [7:0] STAT_READY     = 8'h80;
  localparam logic [7:0] STAT_ERASE_ERR = 8'h20;
  localparam logic [7:0] STAT_PROG_ERR  = 8'h10;

  localparam int unsigned ERR_ERASE_BIT = 1;
  localparam int unsigned ERR_PROG_BIT  = 0;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Query table offsets and fixed bytes.
  localparam logic [7:0] QRY_OFS_Q      = 8'h10;
  localparam logic [7:0] QRY_OFS_R      = 8'h11;
  localparam logic [7:0] QRY_OFS_Y      = 8'h12;
  localparam logic [7:0] QRY_OFS_SIZE   = 8'h27;
  localparam logic [7:0] QRY_OFS_CNT_LO = 8'h2D;
  localparam logic [7:0] QRY_OFS_CNT_HI = 8'h2E;
  localparam logic [7:0] QRY_OFS_UNT_LO = 8'h2F;
  localparam logic [7:0] QRY_OFS_UNT_HI = 8'h30;
  localparam logic [7:0] QRY_CHAR_Q     = 8'h51;
  localparam logic [7:0] QRY_CHAR_R     = 8'h52;
  localparam logic [7:0] QRY_CHAR_Y     = 8'h59;

  typedef struct packed {
    mode_e next_mode;
    logic  clr_err;
    logic  set_erase_err;
    logic  do_prog;
    logic  do_erase;
  } decode_t;

endpackage

`default_nettype wire

// File: hw/rtl/cfinor_if.sv
// Valid/ready channel interfaces for the flash command model: one for bus
// requests, one for results. Depends on cfinor_pkg for the field widths.
`default_nettype none

interface cfinor_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [cfinor_pkg::BUS_ADDR_W-1:0]   address;
  logic [cfinor_pkg::DATA_W-1:0]       write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input address, input write_data,
                output ready);
endinterface

interface cfinor_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [cfinor_pkg::DATA_W-1:0]   read_data;
  logic [cfinor_pkg::MODE_W-1:0]   mode_now;

  modport source (output valid, output read_data, output mode_now, input ready);
  modport sink (input valid, input read_data, input mode_now, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cfinor_decode.sv
// Command decoder: from the current mode and one bus word, works out the next
// mode and which array or status action to take. Depends on cfinor_pkg.
`default_nettype none

module cfinor_decode (
  input  wire cfinor_pkg::mode_e    mode_i,
  input  wire logic                 is_write_i,
  input  wire logic [7:0]           data_i,
  output cfinor_pkg::decode_t       dec_o
);

  always_comb begin
    dec_o               = '0;
    dec_o.next_mode     = mode_i;
    if (is_write_i) begin
      case (mode_i)
        cfinor_pkg::MODE_ERASE: begin
          // Anything but a confirm aborts the erase and flags it.
          if (data_i == cfinor_pkg::CMD_CONFIRM) begin
            dec_o.do_erase = 1'b1;
          end else begin
            dec_o.set_erase_err = 1'b1;
          end
          dec_o.next_mode = cfinor_pkg::MODE_STATUS;
        end
        cfinor_pkg::MODE_PROG: begin
          dec_o.do_prog   = 1'b1;
          dec_o.next_mode = cfinor_pkg::MODE_STATUS;
        end
        default: begin
          case (data_i)
            cfinor_pkg::CMD_READ_ARRAY:  dec_o.next_mode = cfinor_pkg::MODE_ARRAY;
            cfinor_pkg::CMD_QUERY:       dec_o.next_mode = cfinor_pkg::MODE_QUERY;
            cfinor_pkg::CMD_READ_STATUS: dec_o.next_mode = cfinor_pkg::MODE_STATUS;
            cfinor_pkg::CMD_ERASE_SETUP: dec_o.next_mode = cfinor_pkg::MODE_ERASE;
            cfinor_pkg::CMD_PROG_SETUP:  dec_o.next_mode = cfinor_pkg::MODE_PROG;
            cfinor_pkg::CMD_CLEAR_STAT: begin
              dec_o.clr_err   = 1'b1;
              dec_o.next_mode = cfinor_pkg::MODE_ARRAY;
            end
            default: dec_o.next_mode = mode_i;
          endcase
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cfi_nor_flash_command_model_top.sv
// Byte-wide NOR flash command model with a CFI-style command set: holds the
// flash array memory and the sequencer. Depends on cfinor_pkg, cfinor_if and
// cfinor_decode.
//
// Every bus read or write is accepted while the array memory is read, and
// once the output register is free the read data is returned or the
// programmed byte written back through the memory's single write port.
// A result may wait in the output register while the next word is accepted.
// An erase confirm returns its result at once and then sweeps its erase
// block of 2^min(BLOCK_BITS, ADDR_BITS) bytes (4096 by default), one byte a
// cycle, before the next word is taken. After reset the array is cleared to
// 0xFF by a pass over all 2^ADDR_BITS bytes (65536 by default) during which
// no word is accepted.
`default_nettype none

module cfi_nor_flash_command_model_top #(
  parameter int unsigned ADDR_BITS  = cfinor_pkg::ADDR_BITS_DEF,
  parameter int unsigned BLOCK_BITS = cfinor_pkg::BLOCK_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cfinor_req_if.sink   req_i,
  cfinor_rsp_if.source rsp_o
);

  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned Eff = (BLOCK_BITS < ADDR_BITS) ? BLOCK_BITS : ADDR_BITS;
  localparam logic [31:0] QCount  = 32'((64'd1 << (ADDR_BITS - Eff)) - 64'd1);
  localparam logic [31:0] QUnit   = 32'(64'd1 << (Eff - 8));
  localparam logic [AW-1:0] BlkMask = AW'((64'd1 << Eff) - 64'd1);

  cfinor_pkg::state_e state_q, state_d;
  cfinor_pkg::mode_e  mode_q, mode_d;
  logic [1:0]         err_q, err_d;
  logic [AW-1:0]      ptr_q, ptr_d;

  logic               is_wr_q;
  logic [AW-1:0]      addr_q;
  logic [7:0]         data_q;

  logic               rsp_valid_q, rsp_valid_d;
  logic [7:0]         rd_data_q, rd_data_d;
  cfinor_pkg::mode_e  mode_now_q, mode_now_d;

  logic [7:0]         mem [2**AW];
  logic [7:0]         mem_rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [7:0]         mem_wd;

  logic               accept;
  logic               out_free;
  logic               load;
  logic [31:0]        addr_ext;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      sweep_mask;
  logic [7:0]         status_byte;
  logic [7:0]         query_byte;
  cfinor_pkg::decode_t dec;

  cfinor_decode u_decode (
    .mode_i     (mode_q),
    .is_write_i (is_wr_q),
    .data_i     (data_q),
    .dec_o      (dec)
  );

  assign addr_ext      = 32'(req_i.address);
  assign rd_idx        = addr_ext[AW-1:0];
  assign req_i.ready   = (state_q == cfinor_pkg::ST_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign load          = (state_q == cfinor_pkg::ST_EXEC) && out_free;
  assign sweep_mask    = (state_q == cfinor_pkg::ST_CLEAR) ? '1 : BlkMask;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_data = rd_data_q;
  assign rsp_o.mode_now  = mode_now_q;

  always_comb begin
    status_byte = cfinor_pkg::STAT_READY;
    if (err_q[cfinor_pkg::ERR_ERASE_BIT]) begin
      status_byte = status_byte | cfinor_pkg::STAT_ERASE_ERR;
    end
    if (err_q[cfinor_pkg::ERR_PROG_BIT]) begin
      status_byte = status_byte | cfinor_pkg::STAT_PROG_ERR;
    end
  end

  always_comb begin
    case (addr_q[7:0])
      cfinor_pkg::QRY_OFS_Q:      query_byte = cfinor_pkg::QRY_CHAR_Q;
      cfinor_pkg::QRY_OFS_R:      query_byte = cfinor_pkg::QRY_CHAR_R;
      cfinor_pkg::QRY_OFS_Y:      query_byte = cfinor_pkg::QRY_CHAR_Y;
      cfinor_pkg::QRY_OFS_SIZE:   query_byte = 8'(ADDR_BITS);
      cfinor_pkg::QRY_OFS_CNT_LO: query_byte = QCount[7:0];
      cfinor_pkg::QRY_OFS_CNT_HI: query_byte = QCount[15:8];
      cfinor_pkg::QRY_OFS_UNT_LO: query_byte = QUnit[7:0];
      cfinor_pkg::QRY_OFS_UNT_HI: query_byte = QUnit[15:8];
      default:                    query_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    err_d       = err_q;
    ptr_d       = ptr_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rd_data_d   = rd_data_q;
    mode_now_d  = mode_now_q;
    mem_we      = 1'b0;
    mem_wa      = ptr_q;
    mem_wd      = cfinor_pkg::ERASED_BYTE;

    case (state_q)
      cfinor_pkg::ST_CLEAR, cfinor_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
        if ((ptr_q & sweep_mask) == sweep_mask) begin
          state_d = cfinor_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      cfinor_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cfinor_pkg::ST_EXEC;
        end
      end
      cfinor_pkg::ST_EXEC: begin
        // Hold here until the output register can take the result.
        if (load) begin
          rsp_valid_d = 1'b1;
          mode_now_d  = dec.next_mode;
          mode_d      = dec.next_mode;
          if (is_wr_q) begin
            rd_data_d = 8'h00;
          end else begin
            case (mode_q)
              cfinor_pkg::MODE_ARRAY: rd_data_d = mem_rdata_q;
              cfinor_pkg::MODE_QUERY: rd_data_d = query_byte;
              default:                rd_data_d = status_byte;
            endcase
          end
          if (dec.clr_err) begin
            err_d = 2'b00;
          end
          if (dec.set_erase_err) begin
            err_d[cfinor_pkg::ERR_ERASE_BIT] = 1'b1;
          end
          if (dec.do_prog) begin
            mem_we = 1'b1;
            mem_wa = addr_q;
            mem_wd = mem_rdata_q & data_q;
          end
          if (dec.do_erase) begin
            ptr_d   = addr_q & ~BlkMask;
            state_d = cfinor_pkg::ST_SWEEP;
          end else begin
            state_d = cfinor_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = cfinor_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfinor_pkg::ST_CLEAR;
      mode_q      <= cfinor_pkg::MODE_ARRAY;
      err_q       <= 2'b00;
      ptr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      err_q       <= err_d;
      ptr_q       <= ptr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q  <= rd_data_d;
    mode_now_q <= mode_now_d;
    if (accept) begin
      is_wr_q <= req_i.req_type;
      addr_q  <= rd_idx;
      data_q  <= req_i.write_data;
    end
  end

  // Flash array: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_rdata_q <= mem[rd_idx];
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == cfinor_pkg::ST_EXEC)
    else $error("accepted word did not move to execute");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_wr_q) |=> (rsp_o.valid && rsp_o.read_data == 8'h00))
    else $error("write result carries nonzero read data");

  a_exec_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfinor_pkg::ST_EXEC && rsp_valid_q && !rsp_o.ready)
      |=> state_q == cfinor_pkg::ST_EXEC)
    else $error("result dropped while output register was full");

  a_sweep_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cfinor_pkg::ST_SWEEP |-> mode_q == cfinor_pkg::MODE_STATUS)
    else $error("erase sweep outside status mode");

  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != cfinor_pkg::ST_IDLE)
    else $error("array written while idle");

endmodule

`default_nettype wire

// File: tb/sv/cfi_nor_flash_command_model_top_tb.sv
// Testbench for cfi_nor_flash_command_model_top: drives bus reads and writes,
// predicts every result from a shadow copy of the array and the command state.
// Depends on cfinor_pkg, the cfinor_if interfaces and the block's RTL.
`default_nettype none

module cfi_nor_flash_command_model_top_tb;
  import cfinor_pkg::*;

  localparam int unsigned ADDR_BITS      = ADDR_BITS_DEF;
  localparam int unsigned BLOCK_BITS     = BLOCK_BITS_DEF;
  localparam int unsigned EFF_BLOCK_BITS = (BLOCK_BITS < ADDR_BITS) ? BLOCK_BITS : ADDR_BITS;
  localparam int unsigned CHIP_BYTES     = 1 << ADDR_BITS;
  localparam int unsigned BLK_BYTES      = 1 << EFF_BLOCK_BITS;
  localparam int unsigned BLK_COUNT_M1   = (CHIP_BYTES >> EFF_BLOCK_BITS) - 1;
  localparam int unsigned BLK_UNIT       = BLK_BYTES >> 8;

  localparam logic BUS_RD = 1'b0;
  localparam logic BUS_WR = 1'b1;

  localparam int unsigned STALL_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = BLK_BYTES + 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    mode_e             mode;
  } flash_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  cfinor_req_if req_bus ();
  cfinor_rsp_if rsp_bus ();

  cfi_nor_flash_command_model_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow state of the flash chip.
  logic [DATA_W-1:0] shadow_array [0:CHIP_BYTES-1];
  mode_e             shadow_mode;
  logic [1:0]        shadow_err;

  flash_rsp_t  expected_rsp_q [$];
  flash_rsp_t  expected_head;
  int unsigned fail_count   = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned rx_hold_len  = 0;
  logic [BUS_ADDR_W-1:0] addr_pool [16];

  function automatic flash_rsp_t predict_flash_access(input logic is_write,
                                                      input logic [BUS_ADDR_W-1:0] addr_in,
                                                      input logic [DATA_W-1:0] data);
    flash_rsp_t  r;
    int unsigned a;
    int unsigned base;
    a = addr_in & (CHIP_BYTES - 1);
    r.rdata = '0;
    if (is_write) begin
      case (shadow_mode)
        MODE_ERASE: begin
          if (data == CMD_CONFIRM) begin
            base = a & ~(BLK_BYTES - 1);
            for (int i = 0; i < BLK_BYTES; i++) shadow_array[base + i] = ERASED_BYTE;
          end else begin
            shadow_err[ERR_ERASE_BIT] = 1'b1;
          end
          shadow_mode = MODE_STATUS;
        end
        MODE_PROG: begin
          // Programming can only clear bits.
          shadow_array[a] = shadow_array[a] & data;
          shadow_mode = MODE_STATUS;
        end
        default: begin
          case (data)
            CMD_READ_ARRAY:  shadow_mode = MODE_ARRAY;
            CMD_QUERY:       shadow_mode = MODE_QUERY;
            CMD_READ_STATUS: shadow_mode = MODE_STATUS;
            CMD_ERASE_SETUP: shadow_mode = MODE_ERASE;
            CMD_PROG_SETUP:  shadow_mode = MODE_PROG;
            CMD_CLEAR_STAT: begin
              shadow_err  = 2'b00;
              shadow_mode = MODE_ARRAY;
            end
            default: ;
          endcase
        end
      endcase
    end else begin
      case (shadow_mode)
        MODE_ARRAY: r.rdata = shadow_array[a];
        MODE_QUERY: begin
          case (a[7:0])
            QRY_OFS_Q:      r.rdata = QRY_CHAR_Q;
            QRY_OFS_R:      r.rdata = QRY_CHAR_R;
            QRY_OFS_Y:      r.rdata = QRY_CHAR_Y;
            QRY_OFS_SIZE:   r.rdata = 8'(ADDR_BITS);
            QRY_OFS_CNT_LO: r.rdata = 8'(BLK_COUNT_M1);
            QRY_OFS_CNT_HI: r.rdata = 8'(BLK_COUNT_M1 >> 8);
            QRY_OFS_UNT_LO: r.rdata = 8'(BLK_UNIT);
            QRY_OFS_UNT_HI: r.rdata = 8'(BLK_UNIT >> 8);
            default:        r.rdata = 8'h00;
          endcase
        end
        default: begin
          r.rdata = STAT_READY
                  | (shadow_err[ERR_ERASE_BIT] ? STAT_ERASE_ERR : 8'h00)
                  | (shadow_err[ERR_PROG_BIT]  ? STAT_PROG_ERR  : 8'h00);
        end
      endcase
    end
    r.mode = shadow_mode;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a following word does not drop valid in between.
  task automatic send_access(input logic is_write, input logic [BUS_ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      req_bus.valid = 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid      = 1'b1;
    req_bus.req_type   = is_write;
    req_bus.address    = addr;
    req_bus.write_data = data;
    do @(posedge clk_i); while (!req_bus.ready);
    expected_rsp_q.push_back(predict_flash_access(is_write, addr, data));
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [BUS_ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 1) == 0) return addr_pool[$urandom_range(0, 15)];
    return BUS_ADDR_W'($urandom);
  endfunction

  task automatic test_directed_commands();
    // Reads straight after the clearing pass see erased bytes.
    send_access(BUS_RD, 16'h0000, 8'h00);
    send_access(BUS_RD, 16'hFFFF, 8'hFF);
    // Query table, plus an offset outside it.
    send_access(BUS_WR, 16'h0055, CMD_QUERY);
    send_access(BUS_RD, {8'h00, QRY_OFS_Q}, 8'h00);
    send_access(BUS_RD, {8'hFF, QRY_OFS_R}, 8'h00);
    send_access(BUS_RD, {8'h12, QRY_OFS_Y}, 8'h00);
    send_access(BUS_RD, {8'h00, QRY_OFS_SIZE}, 8'h00);
    send_access(BUS_RD, {8'h80, QRY_OFS_CNT_LO}, 8'h00);
    send_access(BUS_RD, {8'h00, QRY_OFS_CNT_HI}, 8'h00);
    send_access(BUS_RD, {8'h00, QRY_OFS_UNT_LO}, 8'h00);
    send_access(BUS_RD, {8'h00, QRY_OFS_UNT_HI}, 8'h00);
    send_access(BUS_RD, 16'hFF31, 8'h00);
    // Program: a read in program setup returns status, data clears bits.
    send_access(BUS_WR, 16'h0000, CMD_PROG_SETUP);
    send_access(BUS_RD, 16'h0000, 8'h00);
    send_access(BUS_WR, 16'hFFFF, 8'h00);
    send_access(BUS_WR, 16'hFFFF, CMD_READ_ARRAY);
    send_access(BUS_RD, 16'hFFFF, 8'h00);
    // A bad confirm sets the erase error; confirm and unknown bytes are ignored.
    send_access(BUS_WR, 16'h1234, CMD_ERASE_SETUP);
    send_access(BUS_WR, 16'h1234, 8'h33);
    send_access(BUS_WR, 16'h1234, CMD_CONFIRM);
    send_access(BUS_WR, 16'h1234, 8'h11);
    send_access(BUS_RD, 16'h1234, 8'h00);
    send_access(BUS_WR, 16'h0000, CMD_CLEAR_STAT);
    // Erase of the top block restores the programmed byte.
    send_access(BUS_WR, 16'hF123, CMD_ERASE_SETUP);
    send_access(BUS_WR, 16'hF123, CMD_CONFIRM);
    send_access(BUS_WR, 16'h0000, CMD_READ_ARRAY);
    send_access(BUS_RD, 16'hFFFF, 8'h00);
  endtask

  task automatic test_random_sequences(input int unsigned n_items, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
    int unsigned           stop_at;
    int unsigned           kind;
    int unsigned           reps;
    logic [BUS_ADDR_W-1:0] a;
    logic [DATA_W-1:0]     d;
    logic [DATA_W-1:0]     ofs;
    stop_at     = items_sent + n_items;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_access(BUS_WR, pick_addr(), CMD_PROG_SETUP);
        if ($urandom_range(0, 3) == 0) send_access(BUS_RD, pick_addr(), DATA_W'($urandom));
        a = pick_addr();
        send_access(BUS_WR, a, DATA_W'($urandom));
        if ($urandom_range(0, 1) == 0) send_access(BUS_RD, a, DATA_W'($urandom));
        send_access(BUS_WR, pick_addr(), CMD_READ_ARRAY);
        send_access(BUS_RD, a, DATA_W'($urandom));
      end else if (kind < 36) begin
        send_access(BUS_WR, pick_addr(), CMD_ERASE_SETUP);
        if ($urandom_range(0, 3) != 0) begin
          send_access(BUS_WR, pick_addr(), CMD_CONFIRM);
        end else begin
          d = DATA_W'($urandom);
          if (d == CMD_CONFIRM) d = ~d;
          send_access(BUS_WR, pick_addr(), d);
        end
        send_access(BUS_RD, pick_addr(), DATA_W'($urandom));
      end else if (kind < 50) begin
        send_access(BUS_WR, pick_addr(), CMD_QUERY);
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          case ($urandom_range(0, 9))
            0: ofs = QRY_OFS_Q;
            1: ofs = QRY_OFS_R;
            2: ofs = QRY_OFS_Y;
            3: ofs = QRY_OFS_SIZE;
            4: ofs = QRY_OFS_CNT_LO;
            5: ofs = QRY_OFS_CNT_HI;
            6: ofs = QRY_OFS_UNT_LO;
            7: ofs = QRY_OFS_UNT_HI;
            default: ofs = 8'($urandom);
          endcase
          send_access(BUS_RD, {8'($urandom), ofs}, DATA_W'($urandom));
        end
      end else if (kind < 62) begin
        send_access(BUS_WR, pick_addr(), CMD_READ_STATUS);
        send_access(BUS_RD, pick_addr(), DATA_W'($urandom));
        if ($urandom_range(0, 1) == 0) send_access(BUS_WR, pick_addr(), CMD_CLEAR_STAT);
      end else if (kind < 85) begin
        send_access(BUS_WR, pick_addr(), CMD_READ_ARRAY);
        reps = $urandom_range(1, 6);
        repeat (reps) send_access(BUS_RD, pick_addr(), DATA_W'($urandom));
      end else begin
        // Noise: any word at all, which may break an open sequence.
        send_access(1'($urandom), BUS_ADDR_W'($urandom), DATA_W'($urandom));
      end
    end
  endtask

  // The receiver stops taking results while words keep coming, so the
  // output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    logic [BUS_ADDR_W-1:0] a;
    tx_idle_pct = 0;
    rx_hold_len = HOLD_CYCLES;
    a = pick_addr();
    send_access(BUS_WR, a, CMD_PROG_SETUP);
    send_access(BUS_WR, a, DATA_W'($urandom));
    send_access(BUS_RD, a, 8'h00);
    send_access(BUS_WR, a, CMD_READ_ARRAY);
    repeat (12) send_access(BUS_RD, pick_addr(), DATA_W'($urandom));
  endtask

  // Result receiver with random idle bursts and an optional long hold.
  initial begin
    int gap;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        rsp_bus.ready = 1'b0;
        gap = rx_hold_len;
        rx_hold_len = 0;
        repeat (gap - 1) @(negedge clk_i);
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        rsp_bus.ready = 1'b0;
        gap = $urandom_range(1, 3);
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_rsp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: read_data %02h mode_now %0d",
                   rsp_bus.read_data, rsp_bus.mode_now);
      end else begin
        expected_head = expected_rsp_q.pop_front();
        if (rsp_bus.read_data !== expected_head.rdata || rsp_bus.mode_now !== expected_head.mode) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result differs: expected read_data %02h mode_now %0d, got %02h %0d",
                     expected_head.rdata, expected_head.mode,
                     rsp_bus.read_data, rsp_bus.mode_now);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cfi_nor_flash_command_model_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = BUS_RD;
    req_bus.address    = '0;
    req_bus.write_data = '0;
    for (int i = 0; i < CHIP_BYTES; i++) shadow_array[i] = ERASED_BYTE;
    shadow_mode = MODE_ARRAY;
    shadow_err  = 2'b00;
    foreach (addr_pool[i]) addr_pool[i] = BUS_ADDR_W'($urandom);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_commands();
    test_random_sequences(500, 25, 25);
    test_output_backpressure();
    test_random_sequences(400, 0, 30);
    test_random_sequences(200, 30, 0);
    test_random_sequences(150, 0, 0);

    req_bus.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cfi_nor_flash_command_model_top: match");
    end else begin
      $display("cfi_nor_flash_command_model_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
